>>> hw/rtl/crt5_pkg.sv
// ----------------------------------------------------------------------------
// crt5_pkg: shared types and constants for the five-modulus CRT unit
// Moduli, Barrett factors, folded Garner coefficients and the mixed-radix
// weights used by the cell chain and the final accumulator.
// ----------------------------------------------------------------------------
package crt5_pkg;

  localparam int NUM_LANES  = 5;
  localparam int NUM_STAGES = NUM_LANES - 1;
  localparam int STAGE_W    = 2;
  localparam int LANE_W     = 3;
  localparam int RES_W      = 31;
  localparam int PROD_W     = 2 * RES_W;
  localparam int VALUE_W    = 64;
  localparam int HALF_W     = VALUE_W / 2;

  // Barrett reduction: quotient estimate from (t >> BAR_IN_SH) * MU >> BAR_OUT_SH
  localparam int BAR_IN_SH  = 30;
  localparam int BAR_OUT_SH = 32;
  localparam int MU_W       = 33;
  localparam int REM_W      = 33;
  localparam int BAR_PROD_W = 2 * MU_W;

  // Port widths of the residues
  localparam int RESIDUE_W [NUM_LANES] = '{30, 30, 31, 31, 31};

  // Moduli
  localparam logic [63:0] P0 = 64'd1073643521;
  localparam logic [63:0] P1 = 64'd1073692673;
  localparam logic [63:0] P2 = 64'd1073750017;
  localparam logic [63:0] P3 = 64'd1073815553;
  localparam logic [63:0] P4 = 64'd1073872897;

  // Inverse of the product of the lower moduli, modulo the next one
  localparam logic [63:0] INV1 = 64'd357919402;
  localparam logic [63:0] INV2 = 64'd589973977;
  localparam logic [63:0] INV3 = 64'd197295683;
  localparam logic [63:0] INV4 = 64'd1004546623;

  // Mixed-radix weight of digit i, reduced modulo prime k (Wk_i)
  localparam logic [63:0] W3_2 = (P0 * P1) % P3;
  localparam logic [63:0] W4_2 = (P0 * P1) % P4;
  localparam logic [63:0] W4_3 = (W4_2 * P2) % P4;

  // Folded coefficients: c_k = r_k*INVk - sum c_i*W_i*INVk (mod Pk)
  localparam logic [63:0] K1_0 = (P1 - INV1) % P1;
  localparam logic [63:0] K2_0 = (P2 - INV2) % P2;
  localparam logic [63:0] K2_1 = (P2 - (P0 * INV2) % P2) % P2;
  localparam logic [63:0] K3_0 = (P3 - INV3) % P3;
  localparam logic [63:0] K3_1 = (P3 - (P0 * INV3) % P3) % P3;
  localparam logic [63:0] K3_2 = (P3 - (W3_2 * INV3) % P3) % P3;
  localparam logic [63:0] K4_0 = (P4 - INV4) % P4;
  localparam logic [63:0] K4_1 = (P4 - (P0 * INV4) % P4) % P4;
  localparam logic [63:0] K4_2 = (P4 - (W4_2 * INV4) % P4) % P4;
  localparam logic [63:0] K4_3 = (P4 - (W4_3 * INV4) % P4) % P4;

  localparam logic [63:0] BAR_ONE = 64'd1 << (BAR_IN_SH + BAR_OUT_SH);

  // Per-cell tables, cell s produces digit s+1
  localparam logic [RES_W-1:0] STG_MOD [NUM_STAGES] = '{
    RES_W'(P1), RES_W'(P2), RES_W'(P3), RES_W'(P4)
  };

  localparam logic [MU_W-1:0] STG_MU [NUM_STAGES] = '{
    MU_W'(BAR_ONE / P1), MU_W'(BAR_ONE / P2), MU_W'(BAR_ONE / P3), MU_W'(BAR_ONE / P4)
  };

  localparam logic [RES_W-1:0] STG_COEF [NUM_STAGES][NUM_LANES] = '{
    '{RES_W'(K1_0), RES_W'(INV1), '0,           '0,           '0},
    '{RES_W'(K2_0), RES_W'(K2_1), RES_W'(INV2), '0,           '0},
    '{RES_W'(K3_0), RES_W'(K3_1), RES_W'(K3_2), RES_W'(INV3), '0},
    '{RES_W'(K4_0), RES_W'(K4_1), RES_W'(K4_2), RES_W'(K4_3), RES_W'(INV4)}
  };

  // Mixed-radix weights modulo 2^64 (products wrap in 64 bits)
  localparam logic [VALUE_W-1:0] RADIX_WT [NUM_LANES] = '{
    64'd1, P0, P0 * P1, P0 * P1 * P2, P0 * P1 * P2 * P3
  };

  typedef logic [RES_W-1:0] lane_t;
  typedef lane_t [NUM_LANES-1:0] lane_vec_t;

  // Transaction moving along the cell chain
  typedef struct packed {
    logic      vld;
    lane_vec_t lane;
  } lane_bus_t;

  // Transaction leaving the accumulator
  typedef struct packed {
    logic               vld;
    logic [VALUE_W-1:0] value;
  } value_bus_t;

endpackage

>>> hw/rtl/crt5_if.sv
// ----------------------------------------------------------------------------
// crt5_if: stream channels of the CRT unit
// Valid/ready channels for the residue tuple and for the rebuilt value.
// ----------------------------------------------------------------------------
interface crt5_in_if;
  import crt5_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [RESIDUE_W[0]-1:0] residue_0;
  logic [RESIDUE_W[1]-1:0] residue_1;
  logic [RESIDUE_W[2]-1:0] residue_2;
  logic [RESIDUE_W[3]-1:0] residue_3;
  logic [RESIDUE_W[4]-1:0] residue_4;

  modport source (
    output valid, residue_0, residue_1, residue_2, residue_3, residue_4,
    input  ready
  );
  modport sink (
    input  valid, residue_0, residue_1, residue_2, residue_3, residue_4,
    output ready
  );
endinterface

interface crt5_out_if;
  import crt5_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] reconstructed_value;

  modport source (output valid, reconstructed_value, input ready);
  modport sink (input valid, reconstructed_value, output ready);
endinterface

>>> hw/rtl/crt5_cell.sv
// ----------------------------------------------------------------------------
// crt5_cell: one Garner stage of the CRT chain
// Forms digit c(stage+1) as a constant-coefficient dot product over the
// lanes, reduced by a pipelined Barrett step, and hands all lanes on.
// ----------------------------------------------------------------------------
module crt5_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [crt5_pkg::STAGE_W-1:0]  stage,
  input  crt5_pkg::lane_bus_t           up,
  output crt5_pkg::lane_bus_t           down
);
  import crt5_pkg::*;

  logic [LANE_W-1:0]     lane_idx;
  logic [RES_W-1:0]      modulus;
  logic [MU_W-1:0]       mu;
  logic [REM_W-1:0]      mod_x2;
  logic [REM_W-1:0]      mod_x3;
  logic [REM_W-1:0]      mod_x4;
  logic [REM_W:0]        mod_x5;

  // combinational terms
  logic [PROD_W-1:0]     prod_c [NUM_LANES];
  logic [VALUE_W-1:0]    sum_c;
  logic [BAR_PROD_W-1:0] bar_prod;
  logic [VALUE_W-1:0]    qm_full;
  logic [RES_W-1:0]      digit;
  lane_vec_t             lanes_out;

  // pipeline registers
  logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
  lane_vec_t             lanes_s1, lanes_s2, lanes_s3, lanes_s4, lanes_s5, lanes_s6;
  logic [PROD_W-1:0]     prod_s1 [NUM_LANES];
  logic [VALUE_W-1:0]    sum_s2;
  logic [REM_W-1:0]      quot_s3;
  logic [REM_W-1:0]      tlo_s3;
  logic [REM_W-1:0]      tlo_s4;
  logic [REM_W-1:0]      qm_s4;
  logic [REM_W-1:0]      rem_s5;

  // cell constants
  assign lane_idx = LANE_W'(stage) + LANE_W'(1);
  assign modulus  = STG_MOD[stage];
  assign mu       = STG_MU[stage];
  assign mod_x2   = REM_W'({modulus, 1'b0});
  assign mod_x3   = mod_x2 + REM_W'(modulus);
  assign mod_x4   = REM_W'({modulus, 2'b00});
  assign mod_x5   = {1'b0, mod_x4} + (REM_W + 1)'(modulus);

  // lane products with the folded coefficients
  always_comb begin
    for (int j = 0; j < NUM_LANES; j++) begin
      prod_c[j] = PROD_W'(up.lane[j]) * PROD_W'(STG_COEF[stage][j]);
    end
  end

  // dot product, bounded below 2^63
  always_comb begin
    sum_c = '0;
    for (int j = 0; j < NUM_LANES; j++) begin
      sum_c = sum_c + VALUE_W'(prod_s1[j]);
    end
  end

  // Barrett quotient estimate, never above the true quotient
  assign bar_prod = BAR_PROD_W'(sum_s2[VALUE_W-2:BAR_IN_SH]) * BAR_PROD_W'(mu);

  // low bits of quotient times modulus
  assign qm_full = VALUE_W'(quot_s3) * VALUE_W'(modulus);

  // remainder is below five moduli: pick the right multiple to remove
  always_comb begin
    priority if (rem_s5 >= mod_x4) begin
      digit = RES_W'(rem_s5 - mod_x4);
    end else if (rem_s5 >= mod_x3) begin
      digit = RES_W'(rem_s5 - mod_x3);
    end else if (rem_s5 >= mod_x2) begin
      digit = RES_W'(rem_s5 - mod_x2);
    end else if (rem_s5 >= REM_W'(modulus)) begin
      digit = RES_W'(rem_s5 - REM_W'(modulus));
    end else begin
      digit = RES_W'(rem_s5);
    end
  end

  // digit replaces the residue in its own lane
  always_comb begin
    lanes_out           = lanes_s5;
    lanes_out[lane_idx] = digit;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s1 <= 1'b0;
      vld_s2 <= 1'b0;
      vld_s3 <= 1'b0;
      vld_s4 <= 1'b0;
      vld_s5 <= 1'b0;
      vld_s6 <= 1'b0;
    end else if (advance) begin
      vld_s1 <= up.vld;
      vld_s2 <= vld_s1;
      vld_s3 <= vld_s2;
      vld_s4 <= vld_s3;
      vld_s5 <= vld_s4;
      vld_s6 <= vld_s5;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (advance) begin
      lanes_s1 <= up.lane;
      prod_s1  <= prod_c;
      lanes_s2 <= lanes_s1;
      sum_s2   <= sum_c;
      lanes_s3 <= lanes_s2;
      quot_s3  <= bar_prod[BAR_OUT_SH+REM_W-1:BAR_OUT_SH];
      tlo_s3   <= sum_s2[REM_W-1:0];
      lanes_s4 <= lanes_s3;
      qm_s4    <= qm_full[REM_W-1:0];
      tlo_s4   <= tlo_s3;
      lanes_s5 <= lanes_s4;
      rem_s5   <= tlo_s4 - qm_s4;
      lanes_s6 <= lanes_out;
    end
  end

  assign down.vld  = vld_s6;
  assign down.lane = lanes_s6;

  // Barrett estimate is off by at most four
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld_s5 |-> ({1'b0, rem_s5} < mod_x5))
    else $error("remainder not below five moduli");

  // handed-on digit is fully reduced
  a_digit_reduced: assert property (@(posedge clk) disable iff (rst)
    down.vld |-> (down.lane[lane_idx] < modulus))
    else $error("digit not below its modulus");

endmodule

>>> hw/rtl/crt5_accum.sv
// ----------------------------------------------------------------------------
// crt5_accum: mixed-radix sum of the five digits
// Multiplies each digit by its weight modulo 2^64 in 32-bit halves and adds
// the five terms through registered per-lane terms, pair sums and a total.
// ----------------------------------------------------------------------------
module crt5_accum (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  crt5_pkg::lane_bus_t   up,
  output crt5_pkg::value_bus_t  down
);
  import crt5_pkg::*;

  localparam int LO_W = RES_W + HALF_W;

  logic [VALUE_W-1:0] lo_full [NUM_LANES];
  logic [VALUE_W-1:0] hi_full [NUM_LANES];

  logic               vld_a, vld_b, vld_c, vld_d;
  logic [LO_W-1:0]    lo_a [NUM_LANES];
  logic [HALF_W-1:0]  hi_a [NUM_LANES];
  logic [VALUE_W-1:0] term_b [NUM_LANES];
  logic [VALUE_W-1:0] pair0_c, pair1_c, tail_c;
  logic [VALUE_W-1:0] total_d;

  // digit times low and high half of its weight
  always_comb begin
    for (int j = 0; j < NUM_LANES; j++) begin
      lo_full[j] = VALUE_W'(up.lane[j]) * VALUE_W'(RADIX_WT[j][HALF_W-1:0]);
      hi_full[j] = VALUE_W'(up.lane[j]) * VALUE_W'(RADIX_WT[j][VALUE_W-1:HALF_W]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
    end else if (advance) begin
      vld_a <= up.vld;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld_d <= vld_c;
    end
  end

  // products, per-lane terms, pair sums, total
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        lo_a[j]   <= lo_full[j][LO_W-1:0];
        hi_a[j]   <= hi_full[j][HALF_W-1:0];
        term_b[j] <= VALUE_W'(lo_a[j]) + {hi_a[j], {HALF_W{1'b0}}};
      end
      pair0_c <= term_b[0] + term_b[1];
      pair1_c <= term_b[2] + term_b[3];
      tail_c  <= term_b[4];
      total_d <= pair0_c + pair1_c + tail_c;
    end
  end

  assign down.vld   = vld_d;
  assign down.value = total_d;

endmodule

>>> hw/rtl/crt5_garner_reconstruct_unit.sv
// ----------------------------------------------------------------------------
// crt5_garner_reconstruct_unit: five-modulus CRT reconstruction
// Rebuilds the low 64 bits of a value from its five residues by Garner's
// mixed-radix method, on a chain of four reduction cells and an accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   residue_ch carries one tuple of five residues per transaction; value_ch
//   returns one 64-bit two's complement value per tuple, in order.
//   Throughput: one transaction per clock cycle while value_ch is ready.
//   Registered path from acceptance to the result on value_ch: six register
//   stages in each of the four Garner cells (dot product, sum, Barrett
//   quotient, quotient times modulus, remainder, final correction), four in
//   the mixed-radix accumulator and the output register.
//   Reset (rst, synchronous) clears every valid bit; nothing in flight
//   survives. No clearing pass is needed afterwards.
//   Stall: when value_ch is not ready, the next result lands in a one-entry
//   skid register and residue_ch.ready drops in the following cycle; the
//   whole pipeline then holds until the output drains. residue_ch.ready comes
//   from a register and has no path from value_ch.ready.
// ----------------------------------------------------------------------------
module crt5_garner_reconstruct_unit (
  input  logic       clk,
  input  logic       rst,
  crt5_in_if.sink    residue_ch,
  crt5_out_if.source value_ch
);
  import crt5_pkg::*;

  logic               advance;
  lane_bus_t          chain [NUM_LANES];
  value_bus_t         acc_out;
  logic               out_v;
  logic               skid_v;
  logic [VALUE_W-1:0] out_val;
  logic [VALUE_W-1:0] skid_val;
  logic               out_stall;

  // the whole pipeline moves while the skid register is free
  assign advance          = !skid_v;
  assign residue_ch.ready = advance;
  assign out_stall        = out_v && !value_ch.ready;

  // residues enter the chain as lanes
  always_comb begin
    chain[0].vld     = residue_ch.valid;
    chain[0].lane[0] = RES_W'(residue_ch.residue_0);
    chain[0].lane[1] = RES_W'(residue_ch.residue_1);
    chain[0].lane[2] = RES_W'(residue_ch.residue_2);
    chain[0].lane[3] = RES_W'(residue_ch.residue_3);
    chain[0].lane[4] = RES_W'(residue_ch.residue_4);
  end

  // Garner cells, one per further modulus
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_cell
    crt5_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .stage   (STAGE_W'(s)),
      .up      (chain[s]),
      .down    (chain[s+1])
    );
  end

  crt5_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .up      (chain[NUM_STAGES]),
    .down    (acc_out)
  );

  // output register and skid: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_stall) begin
      if (advance && acc_out.vld) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_v <= acc_out.vld;
    end
  end

  // output register and skid: data
  always_ff @(posedge clk) begin
    if (out_stall) begin
      if (advance && acc_out.vld) begin
        skid_val <= acc_out.value;
      end
    end else if (skid_v) begin
      out_val <= skid_val;
    end else if (acc_out.vld) begin
      out_val <= acc_out.value;
    end
  end

  assign value_ch.valid               = out_v;
  assign value_ch.reconstructed_value = out_val;

  // skid only holds data behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid holds data while output register is empty");

  // skid fills only when the output was stalled
  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_stall))
    else $error("skid filled without an output stall");

  // a drained skid becomes the next output
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_v && value_ch.ready) |=> (out_v && out_val == $past(skid_val)))
    else $error("skid contents lost on drain");

endmodule

>>> bench/crt5_garner_reconstruct_unit_tb.sv
// ----------------------------------------------------------------------------
// crt5_garner_reconstruct_unit_tb: self-checking bench for the CRT unit
// Drives five-residue tuples into the Garner reconstruction unit and checks
// every 64-bit result against a mixed-radix model kept in the bench. It runs
// directed corner tuples first, then random phases with and without sender
// idling and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crt5_garner_reconstruct_unit_tb;
  import crt5_pkg::*;

  localparam int MAX_SHOWN   = 10;
  localparam int DRAIN_SLACK = 40;   // beyond the pipeline latency

  // residue field widths
  localparam int R0_W = RESIDUE_W[0];
  localparam int R1_W = RESIDUE_W[1];
  localparam int R2_W = RESIDUE_W[2];
  localparam int R3_W = RESIDUE_W[3];
  localparam int R4_W = RESIDUE_W[4];

  typedef struct {
    logic [RESIDUE_W[0]-1:0] r0;
    logic [RESIDUE_W[1]-1:0] r1;
    logic [RESIDUE_W[2]-1:0] r2;
    logic [RESIDUE_W[3]-1:0] r3;
    logic [RESIDUE_W[4]-1:0] r4;
  } residue_tuple_t;

  logic clk;
  logic rst;

  crt5_in_if  residue_ch ();
  crt5_out_if value_ch ();

  crt5_garner_reconstruct_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .residue_ch (residue_ch.sink),
    .value_ch   (value_ch.source)
  );

  // Values still owed by the unit, oldest first
  logic [VALUE_W-1:0] pending_values[$];
  logic [VALUE_W-1:0] want_value;

  int error_count;
  int tuples_sent;
  int values_checked;
  int send_idle_pct;
  int recv_stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("timeout: %0d values still pending", pending_values.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Garner reconstruction, low 64 bits of the exact mixed-radix sum
  function automatic logic [VALUE_W-1:0] garner_value(residue_tuple_t t);
    longint unsigned modv[NUM_LANES];
    longint unsigned invv[NUM_STAGES];
    longint unsigned r[NUM_LANES];
    longint unsigned dig[NUM_LANES];
    longint unsigned acc, w, m, d;
    logic [VALUE_W-1:0] low, wt;
    modv = '{P0, P1, P2, P3, P4};
    invv = '{INV1, INV2, INV3, INV4};
    r    = '{64'(t.r0), 64'(t.r1), 64'(t.r2), 64'(t.r3), 64'(t.r4)};
    // first digit is taken as given, no reduction
    dig[0] = r[0];
    for (int k = 1; k < NUM_LANES; k++) begin
      m   = modv[k];
      acc = 0;
      w   = 1;
      for (int j = 0; j < k; j++) begin
        acc = (acc + (dig[j] % m) * w) % m;
        w   = (w * (modv[j] % m)) % m;
      end
      d      = ((r[k] % m) + m - acc) % m;
      dig[k] = (d * invv[k-1]) % m;
    end
    low = '0;
    wt  = 64'd1;
    for (int k = 0; k < NUM_LANES; k++) begin
      low = low + dig[k] * wt;
      wt  = wt * modv[k];
    end
    return low;
  endfunction

  // Residues of a 64-bit value, all in range
  function automatic residue_tuple_t encode_value(logic [VALUE_W-1:0] x);
    residue_tuple_t t;
    t.r0 = R0_W'(x % P0);
    t.r1 = R1_W'(x % P1);
    t.r2 = R2_W'(x % P2);
    t.r3 = R3_W'(x % P3);
    t.r4 = R4_W'(x % P4);
    return t;
  endfunction

  function automatic residue_tuple_t make_tuple(longint unsigned a, longint unsigned b,
                                                longint unsigned c, longint unsigned e,
                                                longint unsigned f);
    residue_tuple_t t;
    t.r0 = R0_W'(a);
    t.r1 = R1_W'(b);
    t.r2 = R2_W'(c);
    t.r3 = R3_W'(e);
    t.r4 = R4_W'(f);
    return t;
  endfunction

  // Random tuple: mostly in-range residues, some encoded values, some raw bits
  function automatic residue_tuple_t random_tuple();
    residue_tuple_t t;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      t.r0 = R0_W'($urandom_range(32'(P0 - 1)));
      t.r1 = R1_W'($urandom_range(32'(P1 - 1)));
      t.r2 = R2_W'($urandom_range(32'(P2 - 1)));
      t.r3 = R3_W'($urandom_range(32'(P3 - 1)));
      t.r4 = R4_W'($urandom_range(32'(P4 - 1)));
    end else if (pick < 85) begin
      t = encode_value({$urandom(), $urandom()});
    end else begin
      t.r0 = R0_W'($urandom());
      t.r1 = R1_W'($urandom());
      t.r2 = R2_W'($urandom());
      t.r3 = R3_W'($urandom());
      t.r4 = R4_W'($urandom());
    end
    return t;
  endfunction

  task automatic flag_error(string msg);
    if (error_count < MAX_SHOWN) $display("mismatch: %s", msg);
    error_count++;
  endtask

  // Send one tuple; entered and left at a falling edge
  task automatic send_tuple(residue_tuple_t t);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      residue_ch.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    residue_ch.residue_0 = t.r0;
    residue_ch.residue_1 = t.r1;
    residue_ch.residue_2 = t.r2;
    residue_ch.residue_3 = t.r3;
    residue_ch.residue_4 = t.r4;
    residue_ch.valid     = 1'b1;
    do @(posedge clk); while (!residue_ch.ready);
    pending_values.push_back(garner_value(t));
    tuples_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every owed value has come back
  task automatic wait_for_values();
    residue_ch.valid = 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_tuple(random_tuple());
    wait_for_values();
  endtask

  // Corners: zero, field extremes, out-of-range residues, wrap of the result
  task automatic test_directed();
    residue_tuple_t dir_q[$];
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    dir_q.push_back(make_tuple(0, 0, 0, 0, 0));
    dir_q.push_back(encode_value(64'd1));
    dir_q.push_back(encode_value(64'd12345));
    dir_q.push_back(encode_value(64'hFFFF_FFFF_FFFF_FFFF));
    dir_q.push_back(encode_value(64'h8000_0000_0000_0000));
    dir_q.push_back(encode_value(64'h7FFF_FFFF_FFFF_FFFF));
    dir_q.push_back(make_tuple(P0 - 1, P1 - 1, P2 - 1, P3 - 1, P4 - 1));
    // every field at all ones, all beyond their moduli
    dir_q.push_back(make_tuple(64'h3FFF_FFFF, 64'h3FFF_FFFF, 64'h7FFF_FFFF,
                               64'h7FFF_FFFF, 64'h7FFF_FFFF));
    // first residue not reduced
    dir_q.push_back(make_tuple(P0, 0, 0, 0, 0));
    dir_q.push_back(make_tuple(64'h3FFF_FFFF, 0, 0, 0, 0));
    // later residues equal to their modulus reduce to zero
    dir_q.push_back(make_tuple(0, P1, 0, 0, 0));
    dir_q.push_back(make_tuple(0, 0, P2, 0, 0));
    dir_q.push_back(make_tuple(0, 0, 0, P3, 0));
    dir_q.push_back(make_tuple(0, 0, 0, 0, P4));
    dir_q.push_back(make_tuple(0, 0, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF));
    dir_q.push_back(make_tuple(64'h2AAA_AAAA, 64'h1555_5555, 64'h2AAA_AAAA,
                               64'h5555_5555, 64'h2AAA_AAAA));
    dir_q.push_back(make_tuple(64'h1555_5555, 64'h2AAA_AAAA, 64'h5555_5555,
                               64'h2AAA_AAAA, 64'h5555_5555));
    // one lane at the top of its range, the rest zero
    dir_q.push_back(make_tuple(P0 - 1, 0, 0, 0, 0));
    dir_q.push_back(make_tuple(0, P1 - 1, 0, 0, 0));
    dir_q.push_back(make_tuple(0, 0, P2 - 1, 0, 0));
    dir_q.push_back(make_tuple(0, 0, 0, P3 - 1, 0));
    dir_q.push_back(make_tuple(0, 0, 0, 0, P4 - 1));
    foreach (dir_q[i]) send_tuple(dir_q[i]);
    wait_for_values();
  endtask

  task automatic test_no_idling();
    run_random(175, 0, 0);
  endtask

  task automatic test_sender_idle();
    run_random(175, 49, 0);
  endtask

  task automatic test_receiver_stall();
    run_random(175, 0, 49);
  endtask

  task automatic test_both_idle();
    run_random(175, 38, 38);
  endtask

  // Burst, full pause until the pipe is empty, then another burst
  task automatic test_pause_refill();
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    for (int i = 0; i < 20; i++) send_tuple(random_tuple());
    wait_for_values();
    for (int i = 0; i < 20; i++) send_tuple(random_tuple());
    wait_for_values();
  endtask

  // Receiver ready, redrawn every cycle
  initial begin
    value_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      value_ch.ready = rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each returned value with the oldest owed one
  always @(posedge clk) begin
    if (!rst && value_ch.valid && value_ch.ready) begin
      if (pending_values.size() == 0) begin
        flag_error($sformatf("value %0d with none owed", value_ch.reconstructed_value));
      end else begin
        want_value = pending_values.pop_front();
        if (value_ch.reconstructed_value !== want_value)
          flag_error($sformatf("value #%0d expected %0d actual %0d", values_checked,
                               $signed(want_value), value_ch.reconstructed_value));
      end
      values_checked++;
    end
  end

  // Main sequence
  initial begin
    error_count          = 0;
    tuples_sent          = 0;
    values_checked       = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    rst                  = 1'b1;
    residue_ch.valid     = 1'b0;
    residue_ch.residue_0 = '0;
    residue_ch.residue_1 = '0;
    residue_ch.residue_2 = '0;
    residue_ch.residue_3 = '0;
    residue_ch.residue_4 = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_pause_refill();

    wait_for_values();
    repeat (DRAIN_SLACK) @(negedge clk);
    if (pending_values.size() != 0)
      flag_error($sformatf("%0d values never returned", pending_values.size()));

    $display("covered: %0d tuples, %0d values checked, %0d errors", tuples_sent,
             values_checked, error_count);
    $display("phases: corner tuples, steady stream, sender gaps, receiver stalls, both");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/crt5_pkg.sv
hw/rtl/crt5_if.sv
hw/rtl/crt5_cell.sv
hw/rtl/crt5_accum.sv
hw/rtl/crt5_garner_reconstruct_unit.sv
bench/crt5_garner_reconstruct_unit_tb.sv
